// ----- rtl/core/assert_macros.svh -----
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define SRSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SRSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/srsd_pkg.sv -----
// types and constants of the signed rle span decoder
// no dependencies
`default_nettype none

package srsd_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_SPAN_LENGTH      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_SAMPLE = 1'd1;

   // bytes_per_sample code that selects two planes
   localparam logic [1:0] BPS_TWO_PLANES = 2'd2;

   // command queue depth between front and back
   localparam int unsigned CMD_DEPTH = 2;

   // decoder phase, one-hot
   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_VALUE   = 4'b0010,
      PH_LITERAL = 4'b0100,
      PH_SKIP    = 4'b1000
   } phase_type;

   // work handed from front to back: count copies of value
   typedef struct packed {
      logic [7:0] value;
      logic [7:0] count;
      logic       plane;
      logic       span_done;
      logic       error;
   } cmd_type;

   // one packed result
   typedef struct packed {
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [2:0] lane_count;
      logic       plane;
      logic       span_done;
      logic       error;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/srsd_if.sv -----
// request and result channel interfaces of the signed rle span decoder
// no dependencies
`default_nettype none

interface srsd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] bytes_after;

   modport source (output valid, output data_byte, output bytes_after, input ready);
   modport sink   (input valid, input data_byte, input bytes_after, output ready);
endinterface

interface srsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_zero;
   logic [7:0] byte_one;
   logic [7:0] byte_two;
   logic [7:0] byte_three;
   logic [2:0] lane_count;
   logic       plane;
   logic       span_done;
   logic       error;
   logic       last;

   modport source (
      output valid, output byte_zero, output byte_one, output byte_two,
      output byte_three, output lane_count, output plane, output span_done,
      output error, output last, input ready
   );
   modport sink (
      input valid, input byte_zero, input byte_one, input byte_two,
      input byte_three, input lane_count, input plane, input span_done,
      input error, input last, output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/srsd_front.sv -----
// front end: takes record bytes, runs the rle phase machine, emits commands
// depends on srsd_pkg and srsd_if
`default_nettype none

module srsd_front #(
   parameter int unsigned MAX_SPAN = 65535
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [srsd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [srsd_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   srsd_req_if.sink                             req_bus,
   output logic                                 cmd_valid,
   output srsd_pkg::cmd_type                    cmd,
   input  wire                                  cmd_ready
);
   import srsd_pkg::*;

   localparam logic [15:0] MAX_LEN = 16'(MAX_SPAN);

   logic [15:0] span_length_ff, span_length_in;
   logic [1:0]  bps_ff, bps_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  repeat_count_ff, repeat_count_in;
   logic [7:0]  literal_left_ff, literal_left_in;
   logic [15:0] produced_ff, produced_in;
   logic        span_number_ff, span_number_in;

   logic        accept;
   logic [15:0] eff_len;
   logic [15:0] room;
   logic [15:0] run_rep;
   logic [15:0] run_val;
   logic [15:0] lit_run;
   logic [15:0] prod_rep;
   logic [15:0] prod_lit;
   logic [7:0]  lit_dec;
   logic        two_planes;
   logic [7:0]  cnt;
   logic        done;
   logic        err;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = cmd_ready;

   // zero acts as one, anything above the limit is clamped
   assign eff_len = (span_length_ff == '0) ? 16'd1 :
                    ((span_length_ff > MAX_LEN) ? MAX_LEN : span_length_ff);

   assign room     = (produced_ff < eff_len) ? (eff_len - produced_ff) : '0;
   assign run_rep  = {8'd0, repeat_count_ff} + 16'd1;
   assign run_val  = (run_rep > room) ? room : run_rep;
   assign lit_run  = 16'd256 - {8'd0, req_bus.data_byte};
   assign prod_rep = produced_ff + run_val;
   assign prod_lit = produced_ff + 16'd1;
   assign lit_dec  = (literal_left_ff != '0) ? (literal_left_ff - 8'd1) : '0;
   assign two_planes = (span_number_ff == 1'b0) && (bps_ff == BPS_TWO_PLANES);

   // configuration registers
   always_comb begin
      span_length_in = span_length_ff;
      bps_in         = bps_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_SPAN_LENGTH:      span_length_in = csr_wr_data;
            REG_BYTES_PER_SAMPLE: bps_in = csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // phase machine
   always_comb begin
      phase_in        = phase_ff;
      repeat_count_in = repeat_count_ff;
      literal_left_in = literal_left_ff;
      produced_in     = produced_ff;
      span_number_in  = span_number_ff;
      cnt             = '0;
      done            = 1'b0;
      err             = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            if (req_bus.data_byte[7] == 1'b0) begin
               repeat_count_in = req_bus.data_byte;
               phase_in        = PH_VALUE;
            end else if (lit_run > req_bus.bytes_after) begin
               err      = 1'b1;
               phase_in = PH_SKIP;
            end else begin
               literal_left_in = lit_run[7:0];
               phase_in        = PH_LITERAL;
            end
         end
         PH_VALUE: begin
            cnt         = run_val[7:0];
            produced_in = prod_rep;
            if (prod_rep >= eff_len) begin
               done = 1'b1;
               if (two_planes) begin
                  span_number_in = 1'b1;
                  produced_in    = '0;
                  phase_in       = PH_HEADER;
               end else begin
                  phase_in = PH_SKIP;
               end
            end else begin
               phase_in = PH_HEADER;
            end
         end
         PH_LITERAL: begin
            literal_left_in = lit_dec;
            if (produced_ff < eff_len) begin
               cnt         = 8'd1;
               produced_in = prod_lit;
               done        = (prod_lit == eff_len);
            end
            if (lit_dec == '0) begin
               if (produced_in >= eff_len) begin
                  if (two_planes) begin
                     span_number_in = 1'b1;
                     produced_in    = '0;
                     phase_in       = PH_HEADER;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         end
         PH_SKIP: ;
         default: phase_in = PH_HEADER;
      endcase

      // end of record: back to a fresh record whatever happened
      if (req_bus.bytes_after == '0) begin
         if (phase_in != PH_SKIP) begin
            err = 1'b1;
         end
         phase_in        = PH_HEADER;
         repeat_count_in = '0;
         literal_left_in = '0;
         produced_in     = '0;
         span_number_in  = 1'b0;
      end
   end

   assign cmd_valid     = accept && ((cnt != '0) || err || done);
   assign cmd.value     = req_bus.data_byte;
   assign cmd.count     = cnt;
   assign cmd.plane     = span_number_ff;
   assign cmd.span_done = done;
   assign cmd.error     = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_length_ff  <= 16'd1;
         bps_ff          <= 2'd1;
         phase_ff        <= PH_HEADER;
         repeat_count_ff <= '0;
         literal_left_ff <= '0;
         produced_ff     <= '0;
         span_number_ff  <= 1'b0;
      end else begin
         span_length_ff <= span_length_in;
         bps_ff         <= bps_in;
         if (accept) begin
            phase_ff        <= phase_in;
            repeat_count_ff <= repeat_count_in;
            literal_left_ff <= literal_left_in;
            produced_ff     <= produced_in;
            span_number_ff  <= span_number_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/srsd_cmd_fifo.sv -----
// short command queue between the front and back ends
// depends on srsd_pkg
`default_nettype none

module srsd_cmd_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire srsd_pkg::cmd_type  push_cmd,
   output logic                    not_full,
   output logic                    head_valid,
   output srsd_pkg::cmd_type       head_cmd,
   input  wire                     pop
);
   import srsd_pkg::*;

   localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(CMD_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CMD_DEPTH);

   cmd_type            entry_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign not_full   = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/srsd_back.sv -----
// back end: turns queued commands into packed results, one per cycle while the result channel is not stalled
// depends on srsd_pkg and srsd_if
`default_nettype none

module srsd_back #(
   parameter int unsigned LANES = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     cmd_valid,
   input  wire srsd_pkg::cmd_type  cmd,
   output logic                    cmd_pop,
   srsd_rsp_if.source              rsp_bus
);
   import srsd_pkg::*;

   localparam logic [7:0] LANES_B = 8'(LANES);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [7:0] sent_ff, sent_in;
   logic [7:0] rem;
   logic [2:0] lanes;
   logic       fin;
   logic       load;

   assign rem   = cmd.count - sent_ff;
   assign fin   = (rem <= LANES_B);
   assign lanes = fin ? rem[2:0] : LANES_B[2:0];
   assign load  = cmd_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign cmd_pop = load && fin;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      sent_in      = sent_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.byte_zero  = (lanes > 3'd0) ? cmd.value : '0;
         rsp_in.byte_one   = (lanes > 3'd1) ? cmd.value : '0;
         rsp_in.byte_two   = (lanes > 3'd2) ? cmd.value : '0;
         rsp_in.byte_three = (lanes > 3'd3) ? cmd.value : '0;
         rsp_in.lane_count = lanes;
         rsp_in.plane      = cmd.plane;
         rsp_in.span_done  = fin && cmd.span_done;
         rsp_in.error      = fin && cmd.error;
         rsp_in.last       = fin;
         sent_in           = fin ? '0 : (sent_ff + LANES_B);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sent_ff      <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.byte_zero  = rsp_ff.byte_zero;
   assign rsp_bus.byte_one   = rsp_ff.byte_one;
   assign rsp_bus.byte_two   = rsp_ff.byte_two;
   assign rsp_bus.byte_three = rsp_ff.byte_three;
   assign rsp_bus.lane_count = rsp_ff.lane_count;
   assign rsp_bus.plane      = rsp_ff.plane;
   assign rsp_bus.span_done  = rsp_ff.span_done;
   assign rsp_bus.error      = rsp_ff.error;
   assign rsp_bus.last       = rsp_ff.last;

endmodule

`default_nettype wire

// ----- rtl/core/signed_rle_span_decoder.sv -----
// signed run-length span decoder: takes one byte of a channel record per request,
// each tagged with the number of record bytes after it, and returns the decoded
// bytes packed up to four per result. a header byte 0..127 repeats the next byte
// header+1 times, a header byte that is negative as a signed byte passes that many
// literal bytes. each span stops at span_length bytes (0 acts as 1, values above
// MAX_SPAN act as MAX_SPAN); bytes_per_sample 2 adds a low-byte plane, leftover
// bytes are skipped. a repeat header on the last byte, a literal run longer than
// the rest of the record, or a record that ends with spans unfilled sets error on
// the last result of that request. a request that only completes a span or reports
// an error gives one empty result. rate: a header, literal or skipped byte is taken
// every cycle; a repeat run of n bytes is split into ceil(n/lanes) results, lanes
// being OUT_LANES held to 1..4, and the front end stalls once the two-entry command
// queue is full. there is no clearing pass after reset.
// depends on srsd_pkg, srsd_if, srsd_front, srsd_cmd_fifo, srsd_back
`default_nettype none

module signed_rle_span_decoder #(
   parameter int unsigned OUT_LANES = 4,
   parameter int unsigned MAX_SPAN  = 65535
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [srsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [srsd_pkg::CSR_DATA_W-1:0] csr_wr_data,
   srsd_req_if.sink                        req_bus,
   srsd_rsp_if.source                      rsp_bus
);
   import srsd_pkg::*;

   // bytes per result, held to the four output byte fields
   localparam int unsigned LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);

   logic    front_cmd_valid;
   cmd_type front_cmd;
   logic    queue_not_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   // front end: phase machine, one request per cycle while the queue has room
   srsd_front #(
      .MAX_SPAN (MAX_SPAN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .cmd_valid   (front_cmd_valid),
      .cmd         (front_cmd),
      .cmd_ready   (queue_not_full)
   );

   // decouples request intake from result draining
   srsd_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_cmd_valid),
      .push_cmd   (front_cmd),
      .not_full   (queue_not_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (head_pop)
   );

   // back end: splits each command into packed results behind an output register
   srsd_back #(
      .LANES (LANES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- rtl/core/srsd_checker.sv -----
// port-level checks of the signed rle span decoder and their binding
// depends on assert_macros.svh and signed_rle_span_decoder
`default_nettype none

`include "assert_macros.svh"

module srsd_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] byte_zero,
   input wire [7:0] byte_one,
   input wire [7:0] byte_two,
   input wire [7:0] byte_three,
   input wire [2:0] lane_count,
   input wire       plane,
   input wire       span_done,
   input wire       error,
   input wire       last
);

   logic        lanes_clean;
   logic [38:0] rsp_payload;

   // every byte at or above lane_count is zero
   assign lanes_clean = ((lane_count >= 3'd1) || (byte_zero == 8'd0)) &&
                        ((lane_count >= 3'd2) || (byte_one == 8'd0)) &&
                        ((lane_count >= 3'd3) || (byte_two == 8'd0)) &&
                        ((lane_count >= 3'd4) || (byte_three == 8'd0));

   assign rsp_payload = {byte_zero, byte_one, byte_two, byte_three, lane_count,
                         plane, span_done, error, last};

   // no result right after reset
   `SRSD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

   // unused lanes carry zero
   `SRSD_ASSERT(a_lanes_zero, clock, reset, rsp_valid |-> lanes_clean, "nonzero byte beyond lane_count")

   // span_done and error ride only on the last result of a request
   `SRSD_ASSERT(a_flags_last, clock, reset, (rsp_valid && (span_done || error)) |-> last, "status flag on a non-final result")

   // an empty result exists only to carry a status flag
   `SRSD_ASSERT(a_empty_has_flag, clock, reset, (rsp_valid && (lane_count == 3'd0)) |-> (span_done || error), "empty result without status")

   // stalled result holds
   `SRSD_ASSERT(a_stall_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)), "result changed while stalled")

endmodule

bind signed_rle_span_decoder srsd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .byte_zero  (rsp_bus.byte_zero),
   .byte_one   (rsp_bus.byte_one),
   .byte_two   (rsp_bus.byte_two),
   .byte_three (rsp_bus.byte_three),
   .lane_count (rsp_bus.lane_count),
   .plane      (rsp_bus.plane),
   .span_done  (rsp_bus.span_done),
   .error      (rsp_bus.error),
   .last       (rsp_bus.last)
);

`default_nettype wire

// ----- bench/srsd_tb_pkg.sv -----
// scoreboard for the signed rle span decoder bench: predicts packed results per request
// depends on srsd_pkg for the result struct, phase encoding and register indexes
`timescale 1ns / 100ps

package srsd_tb_pkg;
   import srsd_pkg::*;

   localparam int unsigned RESULT_LANES = 4;

   class span_decode_tracker;
      // register copies
      logic [15:0] span_length;
      logic [1:0]  bytes_per_sample;

      // decode state
      phase_type   phase;
      logic [7:0]  repeat_count;
      logic [7:0]  literal_left;
      logic [15:0] produced;
      logic        span_sel;

      rsp_type     pending_words[$];
      int unsigned failures;
      int unsigned requests;
      int unsigned results;
      int unsigned error_flags;
      int unsigned spans_closed;

      function new();
         span_length = 16'd1;
         bytes_per_sample = 2'd1;
         failures = 0;
         requests = 0;
         results = 0;
         error_flags = 0;
         spans_closed = 0;
         clear_record();
      endfunction

      function void clear_record();
         phase = PH_HEADER;
         repeat_count = 8'd0;
         literal_left = 8'd0;
         produced = 16'd0;
         span_sel = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == REG_SPAN_LENGTH)
            span_length = value;
         else if (index == REG_BYTES_PER_SAMPLE)
            bytes_per_sample = value[1:0];
      endfunction

      // span full: move to the low plane or skip what is left
      function void close_span();
         if (span_sel == 1'b0 && bytes_per_sample == BPS_TWO_PLANES) begin
            span_sel = 1'b1;
            produced = 16'd0;
            phase = PH_HEADER;
         end else begin
            phase = PH_SKIP;
         end
      endfunction

      function void accept_record_byte(logic [7:0] value, logic [15:0] bytes_after);
         int unsigned eff_len;
         int unsigned run;
         int unsigned room;
         int unsigned count;
         int unsigned nwords;
         int unsigned lanes;
         int unsigned base;
         logic [7:0] decoded[128];
         bit done;
         bit err;
         bit fin;
         logic cur_plane;
         rsp_type word;

         requests++;
         eff_len = (span_length == 16'd0) ? 1 : span_length;
         count = 0;
         done = 1'b0;
         err = 1'b0;
         cur_plane = span_sel;

         case (phase)
            PH_HEADER: begin
               if (value < 8'd128) begin
                  repeat_count = value;
                  phase = PH_VALUE;
               end else begin
                  run = 256 - value;
                  if (run > bytes_after) begin
                     err = 1'b1;
                     phase = PH_SKIP;
                  end else begin
                     literal_left = run[7:0];
                     phase = PH_LITERAL;
                  end
               end
            end
            PH_VALUE: begin
               run = repeat_count + 1;
               room = (produced < eff_len) ? eff_len - produced : 0;
               if (run > room)
                  run = room;
               for (int k = 0; k < run; k++)
                  decoded[k] = value;
               count = run;
               produced = produced + run[15:0];
               if (produced >= eff_len) begin
                  done = 1'b1;
                  close_span();
               end else begin
                  phase = PH_HEADER;
               end
            end
            PH_LITERAL: begin
               if (produced < eff_len) begin
                  decoded[0] = value;
                  count = 1;
                  produced = produced + 16'd1;
                  if (produced == eff_len)
                     done = 1'b1;
               end
               if (literal_left > 0)
                  literal_left = literal_left - 8'd1;
               if (literal_left == 0) begin
                  if (produced >= eff_len)
                     close_span();
                  else
                     phase = PH_HEADER;
               end
            end
            default: ;
         endcase

         // last byte of the record: unfinished work is an error, then start over
         if (bytes_after == 16'd0) begin
            if (phase != PH_SKIP)
               err = 1'b1;
            clear_record();
         end

         nwords = (count + RESULT_LANES - 1) / RESULT_LANES;
         if (nwords == 0 && (err || done))
            nwords = 1;
         if (err)
            error_flags++;
         if (done)
            spans_closed++;

         for (int r = 0; r < nwords; r++) begin
            base = r * RESULT_LANES;
            lanes = (count > base) ? count - base : 0;
            if (lanes > RESULT_LANES)
               lanes = RESULT_LANES;
            fin = (r == nwords - 1);
            word = '0;
            if (lanes > 0) word.byte_zero = decoded[base];
            if (lanes > 1) word.byte_one = decoded[base + 1];
            if (lanes > 2) word.byte_two = decoded[base + 2];
            if (lanes > 3) word.byte_three = decoded[base + 3];
            word.lane_count = lanes[2:0];
            word.plane = cur_plane;
            word.span_done = fin && done;
            word.error = fin && err;
            word.last = fin;
            pending_words.push_back(word);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
         end
      endfunction

      function void check_packed_result(rsp_type got);
         rsp_type want;
         results++;
         if (pending_words.size() == 0) begin
            $error("result with nothing expected: lane_count %0d plane %0d",
                   got.lane_count, got.plane);
            failures++;
            return;
         end
         want = pending_words.pop_front();
         compare_field("byte_zero", want.byte_zero, got.byte_zero);
         compare_field("byte_one", want.byte_one, got.byte_one);
         compare_field("byte_two", want.byte_two, got.byte_two);
         compare_field("byte_three", want.byte_three, got.byte_three);
         compare_field("lane_count", want.lane_count, got.lane_count);
         compare_field("plane", want.plane, got.plane);
         compare_field("span_done", want.span_done, got.span_done);
         compare_field("error", want.error, got.error);
         compare_field("last", want.last, got.last);
      endfunction

      function void report_leftovers();
         if (pending_words.size() != 0) begin
            $error("%0d expected results never arrived", pending_words.size());
            failures++;
         end
      endfunction
   endclass

endpackage

// ----- bench/tb_signed_rle_span_decoder.sv -----
// top of the signed rle span decoder bench: clock, reset, request and result drivers,
// directed records followed by random well-formed and broken records under three idle mixes
// depends on srsd_pkg, srsd_if, srsd_tb_pkg and the decoder itself
`timescale 1ns / 100ps

module tb_signed_rle_span_decoder;
   import srsd_pkg::*;
   import srsd_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 10;   // covers front end, command queue and back end
   localparam int unsigned HOLD_CYCLES   = 400;  // long result back-pressure stretch
   localparam int unsigned PHASE_ITEMS   = 100;  // random requests per idle mix

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   srsd_req_if req_bus ();
   srsd_rsp_if rsp_bus ();

   signed_rle_span_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   span_decode_tracker tracker = new();

   // record under construction: bytes and their bytes_after tags
   logic [7:0]  rec_q[$];
   logic [15:0] after_q[$];

   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   bit          hold_request;
   int unsigned cycle_count = 0;
   int unsigned sent_items = 0;
   int unsigned sent_records = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d results outstanding",
                  tracker.pending_words.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // both handshakes sampled at the rising edge; the request is noted first in case a
   // result could follow in the same cycle
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && req_bus.valid && req_bus.ready)
         tracker.accept_record_byte(req_bus.data_byte, req_bus.bytes_after);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.byte_zero  = rsp_bus.byte_zero;
         got.byte_one   = rsp_bus.byte_one;
         got.byte_two   = rsp_bus.byte_two;
         got.byte_three = rsp_bus.byte_three;
         got.lane_count = rsp_bus.lane_count;
         got.plane      = rsp_bus.plane;
         got.span_done  = rsp_bus.span_done;
         got.error      = rsp_bus.error;
         got.last       = rsp_bus.last;
         tracker.check_packed_result(got);
      end
   end

   // result ready: random stalls, or a long hold-off when asked for
   always begin
      @(negedge clock);
      if (hold_request) begin
         rsp_bus.ready <= 1'b0;
         hold_request = 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // all driver tasks start and end just after a falling edge

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= value[CSR_DATA_W-1:0];
      tracker.write_reg(index, value[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // one request, with random idle cycles ahead of it; valid is left high on return
   task automatic send_byte(input logic [7:0] value, input logic [15:0] bytes_after);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.bytes_after <= bytes_after;
      do
         @(posedge clock);
      while (!req_bus.ready);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] value, input logic [15:0] bytes_after);
      rec_q.push_back(value);
      after_q.push_back(bytes_after);
   endtask

   task automatic send_queued();
      foreach (rec_q[i])
         send_byte(rec_q[i], after_q[i]);
      req_bus.valid <= 1'b0;
      rec_q.delete();
      after_q.delete();
      sent_records++;
      @(negedge clock);
   endtask

   // wait for every expected result, then let any empty-handed work finish
   task automatic settle();
      while (tracker.pending_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // true tags count down to 0; scrambled ones are random but nonzero except the last
   task automatic stamp_afters(input bit scramble);
      int unsigned left;
      after_q.delete();
      foreach (rec_q[i]) begin
         left = rec_q.size() - 1 - i;
         if (scramble && left != 0)
            left = $urandom_range(65535, 1);
         after_q.push_back(left[15:0]);
      end
   endtask

   // well-formed spans of mixed repeat and literal runs, plus up to two trailing bytes
   task automatic build_record(input int unsigned span_len, input int unsigned planes);
      int unsigned got_len;
      int unsigned n;
      bit big;
      for (int p = 0; p < planes; p++) begin
         got_len = 0;
         while (got_len < span_len) begin
            big = (span_len > 32) || ($urandom_range(9) == 0);
            n = big ? $urandom_range(128, 1) : $urandom_range(8, 1);
            if ($urandom_range(1) == 0) begin
               rec_q.push_back(8'(n - 1));          // repeat header
               rec_q.push_back(8'($urandom()));
            end else begin
               rec_q.push_back(8'(256 - n));        // literal header
               repeat (n) rec_q.push_back(8'($urandom()));
            end
            got_len += n;
         end
      end
      repeat ($urandom_range(2)) rec_q.push_back(8'($urandom()));
   endtask

   function automatic int unsigned pick_span();
      case ($urandom_range(9))
         0:       return 1;
         7, 8:    return $urandom_range(64, 17);
         9:       return $urandom_range(200, 65);
         default: return $urandom_range(16, 2);
      endcase
   endfunction

   task automatic random_record(input int unsigned span_len, input int unsigned planes);
      int unsigned mode;
      int unsigned n;
      mode = $urandom_range(9);
      if (mode == 8) begin
         // noise
         repeat ($urandom_range(10, 1)) rec_q.push_back(8'($urandom()));
      end else begin
         build_record(span_len, planes);
         if (mode == 7) begin
            // cut short anywhere: missing value bytes and unfilled spans
            n = $urandom_range(rec_q.size() - 1);
            repeat (n) void'(rec_q.pop_back());
         end else if (mode == 9) begin
            // literal run longer than the rest of the record, unless the cap of 128 is reached
            n = rec_q.size() + 1;
            if (n > 128)
               n = 128;
            rec_q.push_front(8'(256 - n));
         end
      end
      stamp_afters(mode == 6);
      send_queued();
   endtask

   initial begin
      int unsigned span_len;
      int unsigned planes;
      int unsigned phase_start;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.bytes_after = '0;
      rsp_bus.ready = 1'b0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed records ---

      // reset config: one-byte span from a single repeat
      queue_byte(8'h00, 16'd1);
      queue_byte(8'hAA, 16'd0);
      send_queued();
      settle();

      write_reg(REG_SPAN_LENGTH, 8);
      write_reg(REG_BYTES_PER_SAMPLE, 2);

      // two planes: longest repeat clamped at the span, literal then repeat, trailing skip
      queue_byte(8'd127, 16'd7);
      queue_byte(8'h5A, 16'd6);
      queue_byte(8'hFE, 16'd5);
      queue_byte(8'hFF, 16'd4);
      queue_byte(8'h00, 16'd3);
      queue_byte(8'd5, 16'd2);
      queue_byte(8'h11, 16'd1);
      queue_byte(8'h33, 16'd0);
      // repeat header as the record's last byte
      queue_byte(8'd3, 16'd0);
      // literal run longer than the record
      queue_byte(8'hF0, 16'd2);
      queue_byte(8'd1, 16'd1);
      queue_byte(8'd2, 16'd0);
      // record ends before the span is full
      queue_byte(8'd1, 16'd1);
      queue_byte(8'h22, 16'd0);
      // largest literal accepted on an oversized tag, tags not consistent
      queue_byte(8'h80, 16'hFFFF);
      queue_byte(8'h01, 16'h8000);
      queue_byte(8'h02, 16'd0);
      send_queued();

      // span shrinks below what was already produced, mid record
      queue_byte(8'd2, 16'd3);
      queue_byte(8'h44, 16'd2);
      send_queued();
      settle();
      write_reg(REG_SPAN_LENGTH, 2);
      queue_byte(8'd0, 16'd1);
      queue_byte(8'h55, 16'd0);
      send_queued();
      settle();

      // span length zero acts as one, odd plane code gives one span
      write_reg(REG_SPAN_LENGTH, 0);
      write_reg(REG_BYTES_PER_SAMPLE, 3);
      queue_byte(8'h00, 16'd1);
      queue_byte(8'h9C, 16'd0);
      send_queued();
      settle();

      // widest span, plane code zero, record far too short
      write_reg(REG_SPAN_LENGTH, 65535);
      write_reg(REG_BYTES_PER_SAMPLE, 0);
      queue_byte(8'hFF, 16'd1);
      queue_byte(8'h77, 16'd0);
      send_queued();
      settle();

      // --- random records under three idle mixes ---
      for (int mix = 0; mix < 3; mix++) begin
         req_idle_pct = (mix == 0) ? 17 : (mix == 1) ? 53 : 0;
         rsp_idle_pct = (mix == 0) ? 53 : (mix == 1) ? 17 : 0;
         phase_start = sent_items;

         if (mix == 0) begin
            // long result hold-off while the sender keeps offering big repeat runs
            write_reg(REG_SPAN_LENGTH, 600);
            write_reg(REG_BYTES_PER_SAMPLE, 1);
            hold_request = 1'b1;
            repeat (5) begin
               rec_q.push_back(8'($urandom_range(127, 100)));
               rec_q.push_back(8'($urandom()));
            end
            stamp_afters(1'b0);
            send_queued();
            settle();
         end

         span_len = pick_span();
         planes = $urandom_range(2, 1);
         write_reg(REG_SPAN_LENGTH, span_len);
         write_reg(REG_BYTES_PER_SAMPLE, planes);

         while (sent_items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(3) == 0) begin
               settle();
               span_len = pick_span();
               planes = $urandom_range(2, 1);
               write_reg(REG_SPAN_LENGTH, span_len);
               write_reg(REG_BYTES_PER_SAMPLE, planes);
            end
            random_record(span_len, planes);
         end
         settle();
      end

      while (tracker.pending_words.size() != 0)
         @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      tracker.report_leftovers();

      $display("%0d requests in %0d records gave %0d results",
               tracker.requests, sent_records, tracker.results);
      $display("%0d error flags and %0d completed spans predicted",
               tracker.error_flags, tracker.spans_closed);
      if (tracker.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- signed_rle_span_decoder.f -----
+incdir+rtl/core
rtl/core/srsd_pkg.sv
rtl/core/srsd_if.sv
rtl/core/srsd_front.sv
rtl/core/srsd_cmd_fifo.sv
rtl/core/srsd_back.sv
rtl/core/signed_rle_span_decoder.sv
rtl/core/srsd_checker.sv
bench/srsd_tb_pkg.sv
bench/tb_signed_rle_span_decoder.sv
